[rtl/core/prct_pkg.sv]
// Shared types, sizes and helpers for the page range coalescing table.
package prct_pkg;

  localparam int MAX_RANGES = 16;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;

  typedef enum logic [2:0] {
    ST_EMPTY     = 3'd0,
    ST_COVERED   = 3'd1,
    ST_WIDENED   = 3'd2,
    ST_APPENDED  = 3'd3,
    ST_FULL      = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_BAD_INDEX = 3'd6
  } status_t;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // One stored range, in pages, end exclusive.
  typedef struct packed {
    logic [PAGE_W-1:0] start_pg;
    logic [PAGE_W-1:0] end_pg;
  } entry_t;

  // Request after page rounding.
  typedef struct packed {
    op_t               op;
    logic              zero_len;
    logic [PAGE_W-1:0] start_pg;
    logic [PAGE_W-1:0] end_pg;
    logic [IDX_W-1:0]  idx;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  slot;
    logic [ADDR_W-1:0] span_start;
    logic [ADDR_W-1:0] span_end;
    logic [CNT_W-1:0]  entries_used;
  } res_t;

  function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_W-1:0] pg);
    page_addr = {pg, {PAGE_SHIFT{1'b0}}};
  endfunction

endpackage

[rtl/core/prct_ram.sv]
// Generic single-port-write, registered-read RAM.
module prct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/prct_ctrl.sv]
// Sequencer: scans the range store, widens, appends and reads back entries.
module prct_ctrl
  import prct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_in,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_CMP    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t           state, state_next;
  req_t             req, req_next;
  res_t             res_next;
  logic [IDX_W-1:0] scan_idx, scan_idx_next;
  logic [CNT_W-1:0] used, used_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic             finish_new;
  logic [CNT_W-1:0] scan_inc;
  logic [PAGE_W-1:0] wide_start, wide_end;

  prct_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_RANGES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign scan_inc  = {1'b0, scan_idx} + CNT_W'(1);
  assign wide_start = (req.start_pg < ram_rdata.start_pg) ? req.start_pg : ram_rdata.start_pg;
  assign wide_end   = (req.end_pg > ram_rdata.end_pg) ? req.end_pg : ram_rdata.end_pg;

  always_comb begin
    state_next    = state;
    req_next      = req;
    res_next      = res;
    scan_idx_next = scan_idx;
    used_next     = used;
    ram_we        = 1'b0;
    ram_waddr     = scan_idx;
    ram_wdata     = '{start_pg: req.start_pg, end_pg: req.end_pg};
    ram_raddr     = scan_idx;
    finish_new    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_next   = req_in;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (req.op == OP_READ) begin
          if ({1'b0, req.idx} < used) begin
            ram_raddr  = req.idx;
            state_next = S_RDWAIT;
          end else begin
            res_next   = '{ST_BAD_INDEX, req.idx, '0, '0, used};
            state_next = S_DONE;
          end
        end else if (req.zero_len) begin
          res_next   = '{ST_EMPTY, '0, '0, '0, used};
          state_next = S_DONE;
        end else if (used == '0) begin
          finish_new = 1'b1;
        end else begin
          ram_raddr     = '0;
          scan_idx_next = '0;
          state_next    = S_CMP;
        end
      end
      S_RDWAIT: begin
        res_next   = '{ST_READ_OK, req.idx, page_addr(ram_rdata.start_pg),
                       page_addr(ram_rdata.end_pg), used};
        state_next = S_DONE;
      end
      S_CMP: begin
        if (req.start_pg >= ram_rdata.start_pg && req.end_pg <= ram_rdata.end_pg) begin
          res_next   = '{ST_COVERED, scan_idx, page_addr(ram_rdata.start_pg),
                         page_addr(ram_rdata.end_pg), used};
          state_next = S_DONE;
        end else if (req.start_pg <= ram_rdata.end_pg &&
                     req.end_pg >= ram_rdata.start_pg) begin
          ram_we     = 1'b1;
          ram_waddr  = scan_idx;
          ram_wdata  = '{start_pg: wide_start, end_pg: wide_end};
          res_next   = '{ST_WIDENED, scan_idx, page_addr(wide_start),
                         page_addr(wide_end), used};
          state_next = S_DONE;
        end else if (scan_inc >= used) begin
          finish_new = 1'b1;
        end else begin
          // advance: fetch the next entry while this one is compared
          scan_idx_next = scan_inc[IDX_W-1:0];
          ram_raddr     = scan_inc[IDX_W-1:0];
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish_new) begin
      state_next = S_DONE;
      if (used >= CNT_W'(MAX_RANGES)) begin
        res_next = '{ST_FULL, '0, page_addr(req.start_pg), page_addr(req.end_pg), used};
      end else begin
        ram_we    = 1'b1;
        ram_waddr = used[IDX_W-1:0];
        used_next = used + CNT_W'(1);
        res_next  = '{ST_APPENDED, used[IDX_W-1:0], page_addr(req.start_pg),
                      page_addr(req.end_pg), used_next};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
    req      <= req_next;
    res      <= res_next;
    scan_idx <= scan_idx_next;
  end

endmodule

[rtl/core/page_range_coalescing_table.sv]
// Top level of the page range coalescing table: handshakes, rounding, result register.
//
// Holds up to 16 page-aligned address ranges (4 KiB pages) in a 16-entry
// synchronous RAM. A record word rounds base down and base+length up to a
// page boundary (32-bit wrap), then walks the valid entries in order and
// stops at the first that contains, overlaps or touches the range: such an
// entry is reported as covered if it contains the range, else it is widened
// in place. When no entry matches, the range is appended, or table full is
// reported with the rounded range. A zero length is reported as ignored. A
// read word returns one stored entry, or bad index for an index at or above
// the fill count. The store has no clearing pass: only entries below the
// fill count are ever read. Sequencing: a trivially answered request (zero
// length, bad index, append to an empty table) goes from the prepare state
// straight to the done state, a read of a stored entry passes through a wait
// state for the RAM's registered read, and a record that scans compares the
// stored entries in order, one per cycle through the registered read port.
// One request is in the sequencer at a time; a finished result sits in the
// output register while the next request word is accepted.
module page_range_coalescing_table
  import prct_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [ADDR_W-1:0]   base_address,
  input  logic [ADDR_W-1:0]   length_bytes,
  input  logic [IDX_W-1:0]    entry_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [IDX_W-1:0]    slot,
  output logic [ADDR_W-1:0]   span_start,
  output logic [ADDR_W-1:0]   span_end,
  output logic [CNT_W-1:0]    entries_used
);

  req_t              req;
  res_t              core_res;
  res_t              out_res;
  logic              core_valid;
  logic              core_take;
  logic [ADDR_W-1:0] end_sum;

  // Round the request to pages: start truncates, end rounds up with wrap.
  assign end_sum      = base_address + length_bytes;
  assign req.op       = op_t'(operation);
  assign req.zero_len = (length_bytes == '0);
  assign req.start_pg = base_address[ADDR_W-1:PAGE_SHIFT];
  assign req.end_pg   = end_sum[ADDR_W-1:PAGE_SHIFT] +
                        PAGE_W'(|end_sum[PAGE_SHIFT-1:0]);
  assign req.idx      = entry_index;

  prct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(in_valid),
    .req_ready(in_ready),
    .req_in   (req),
    .res_valid(core_valid),
    .res_ready(core_take),
    .res      (core_res)
  );

  // Load the output register when it is empty or its word is being taken.
  assign core_take = core_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (core_take) begin
      out_res <= core_res;
    end
  end

  assign status       = out_res.status;
  assign slot         = out_res.slot;
  assign span_start   = out_res.span_start;
  assign span_end     = out_res.span_end;
  assign entries_used = out_res.entries_used;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the page range coalescing table.
`timescale 1ns / 1ps

module tb_top
  import prct_pkg::*;
;

  // Own copy of the range table, the results still owed by the block, and the
  // comparison of each returned word against the oldest one owed.
  class coalesce_scoreboard;
    logic [PAGE_W-1:0] start_pg [MAX_RANGES];
    logic [PAGE_W-1:0] end_pg [MAX_RANGES];
    logic [CNT_W-1:0]  fill;
    res_t              awaited_results[$];
    int unsigned       mismatches;

    function new();
      fill = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function void queue_outcome(status_t st, logic [IDX_W-1:0] sl,
                                logic [ADDR_W-1:0] rs, logic [ADDR_W-1:0] re);
      res_t r;
      r.status       = st;
      r.slot         = sl;
      r.span_start   = rs;
      r.span_end     = re;
      r.entries_used = fill;
      awaited_results.push_back(r);
    endfunction

    // Work out what one accepted request word yields and update the table copy.
    function void note_request(op_t op, logic [ADDR_W-1:0] base,
                               logic [ADDR_W-1:0] len, logic [IDX_W-1:0] idx);
      logic [ADDR_W-1:0] page_mask;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [ADDR_W-1:0] rs;
      logic [ADDR_W-1:0] re;
      page_mask = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
      if (op == OP_READ) begin
        if (idx < fill)
          queue_outcome(ST_READ_OK, idx, {start_pg[idx], {PAGE_SHIFT{1'b0}}},
                        {end_pg[idx], {PAGE_SHIFT{1'b0}}});
        else
          queue_outcome(ST_BAD_INDEX, idx, '0, '0);
        return;
      end
      if (len == '0) begin
        queue_outcome(ST_EMPTY, '0, '0, '0);
        return;
      end
      // Round outwards to whole pages; the end wraps at 2^32 and stays wrapped.
      lo = base & ~page_mask;
      hi = base + len;
      hi = (hi + page_mask) & ~page_mask;
      for (int i = 0; i < fill; i++) begin
        rs = {start_pg[i], {PAGE_SHIFT{1'b0}}};
        re = {end_pg[i], {PAGE_SHIFT{1'b0}}};
        if (lo >= rs && hi <= re) begin
          queue_outcome(ST_COVERED, IDX_W'(i), rs, re);
          return;
        end
        if (lo <= re && hi >= rs) begin
          if (lo < rs) rs = lo;
          if (hi > re) re = hi;
          start_pg[i] = rs[ADDR_W-1:PAGE_SHIFT];
          end_pg[i]   = re[ADDR_W-1:PAGE_SHIFT];
          queue_outcome(ST_WIDENED, IDX_W'(i), rs, re);
          return;
        end
      end
      if (fill >= MAX_RANGES) begin
        queue_outcome(ST_FULL, '0, lo, hi);
      end else begin
        start_pg[fill] = lo[ADDR_W-1:PAGE_SHIFT];
        end_pg[fill]   = hi[ADDR_W-1:PAGE_SHIFT];
        fill = fill + 1'b1;
        queue_outcome(ST_APPENDED, IDX_W'(fill - 1'b1), lo, hi);
      end
    endfunction

    function void check_result(logic [2:0] st, logic [IDX_W-1:0] sl,
                               logic [ADDR_W-1:0] rs, logic [ADDR_W-1:0] re,
                               logic [CNT_W-1:0] used);
      res_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d slot %0d start %h end %h used %0d",
                   st, sl, rs, re, used);
        return;
      end
      want = awaited_results.pop_front();
      if (st !== want.status || sl !== want.slot || rs !== want.span_start ||
          re !== want.span_end || used !== want.entries_used) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected status %0d slot %0d start %h end %h used %0d",
                   want.status, want.slot, want.span_start, want.span_end,
                   want.entries_used);
          $display("          actual   status %0d slot %0d start %h end %h used %0d",
                   st, sl, rs, re, used);
        end
      end
    endfunction
  endclass

  localparam int RANDOM_WORDS  = 1100;
  localparam int HOLD_AT       = 120;   // results seen before the long hold-off
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 40;    // longer than the longest scan

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              operation = 1'b0;
  logic [ADDR_W-1:0] base_address = '0;
  logic [ADDR_W-1:0] length_bytes = '0;
  logic [IDX_W-1:0]  entry_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        status;
  logic [IDX_W-1:0]  slot;
  logic [ADDR_W-1:0] span_start;
  logic [ADDR_W-1:0] span_end;
  logic [CNT_W-1:0]  entries_used;

  coalesce_scoreboard sb;

  // Idle percentages of the sender and the receiver, per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_send [4] = '{0, 87, 0, 24};
  int unsigned phase_recv [4] = '{0, 0, 87, 24};

  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned quiet = 0;

  page_range_coalescing_table u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .base_address (base_address),
    .length_bytes (length_bytes),
    .entry_index  (entry_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot         (slot),
    .span_start   (span_start),
    .span_end     (span_end),
    .entries_used (entries_used)
  );

  always #5 clk = ~clk;

  // Offer one request word, perhaps after a random gap, and hold it until the
  // block takes it. Valid is only lowered when a gap is actually taken, so a
  // back-to-back word never sees valid dropped and raised in one step.
  task automatic send_word(input op_t op, input logic [ADDR_W-1:0] base,
                           input logic [ADDR_W-1:0] len, input logic [IDX_W-1:0] idx);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    base_address <= base;
    length_bytes <= len;
    entry_index  <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // Pause the sender until every owed result word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly records clustered around the stored ranges so that covering and
  // widening keep happening; some reads, empty records and far-flung noise.
  task automatic send_random_word();
    int unsigned pick;
    int unsigned k;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    pick = $urandom_range(0, 99);
    base = $urandom;
    len  = $urandom;
    if (pick < 12) begin
      send_word(OP_READ, base, len, IDX_W'($urandom_range(0, 15)));
    end else if (pick < 15) begin
      send_word(OP_RECORD, base, '0, IDX_W'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        k = $urandom_range(0, MAX_RANGES - 1);
        base = (k == 0) ? 32'h0000_1000 : ((ADDR_W'(k) << 24) | 32'h0004_0000);
        base = base + $urandom_range(0, 32'h8000) - 32'h4000;
      end else if (pick < 70) begin
        base = 32'hFFFF_0000 | ($urandom & 32'h0000_FFFF);
      end
      pick = $urandom_range(0, 99);
      if (pick < 65)
        len = $urandom_range(1, 32'h4000);
      else if (pick < 90)
        len = $urandom_range(1, 32'h0100_0000);
      if (len == '0) len = 1;
      send_word(OP_RECORD, base, len, IDX_W'($urandom));
    end
  endtask

  // Note each accepted request and check each accepted result at the edge
  // where it moves; inputs are driven with nonblocking writes, so the values
  // seen here are the ones the block saw.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_request(op_t'(operation), base_address, length_bytes, entry_index);
      if (out_valid && out_ready) begin
        sb.check_result(status, slot, span_start, span_end, entries_used);
        results_seen <= results_seen + 1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // offering words, so the block fills up and drops in_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reads of an empty table, one with every other field at its top value.
    send_word(OP_READ, '0, '0, '0);
    send_word(OP_READ, '1, '1, 4'hF);
    // Zero length is ignored whatever the base.
    send_word(OP_RECORD, '1, '0, '0);
    // Append one page, then a range inside it.
    send_word(OP_RECORD, 32'h0000_1000, 32'h0000_0001, '0);
    send_word(OP_RECORD, 32'h0000_1800, 32'h0000_0010, '0);
    // Touch the end, then the start: both widen the same entry.
    send_word(OP_RECORD, 32'h0000_2000, 32'h0000_1000, '0);
    send_word(OP_RECORD, 32'h0000_0FFF, 32'h0000_0001, '0);
    // End wraps past the top of the address space to zero.
    send_word(OP_RECORD, 32'hFFFF_F000, 32'h0000_1000, '0);
    send_word(OP_READ, '0, '0, '0);
    // Fill the table with separate ranges, then ask for one more, which finds it full.
    for (int k = 1; k < MAX_RANGES; k++)
      send_word(OP_RECORD, (ADDR_W'(k) << 24) | 32'h0004_0000, 32'h0000_2000, '0);
    send_word(OP_RECORD, 32'h8000_0000, 32'h0000_0010, '0);
    send_word(OP_READ, '0, '0, 4'hF);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      repeat (RANDOM_WORDS / 4) send_random_word();
      drain();
    end

    // Let any stray result word surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
